// ===== sv/sla_pkg.sv =====
// Shared constants, codes and types for the semi-Lagrangian bilinear advection block.
// No dependencies; every other file of the block but sla_bank imports it.
`default_nettype none

package sla_pkg;

	// Field widths
	localparam int PIDX_W  = 7;   // cell index on the stream
	localparam int VAL_W   = 16;  // Q1.15 cell value
	localparam int VEL_W   = 16;  // Q2.14 velocity
	localparam int DT_W    = 12;  // Q4.8 time step
	localparam int FRAC_W  = 12;  // fractional bits of a traced position
	localparam int PROD_W  = DT_W + 1 + VEL_W;  // dt * v, signed
	localparam int WGT_W   = 2 * FRAC_W + 1;    // one bilinear weight, up to 2^24
	localparam int PP_W    = 2 * FRAC_W + VAL_W; // weighted value and the sum of four

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 16;

	localparam int GRID_SIZE_DEF = 128;
	localparam logic [DT_W-1:0] DT_RESET = DT_W'(256);

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} sla_op_t;

	// per-stage control
	typedef struct packed {
		logic valid;
		logic sample;
		logic border;
		logic wr;
	} sla_ctl_t;

	// stage load enables handed to the blend datapath
	typedef struct packed {
		logic s3;
		logic s4;
	} sla_adv_t;

endpackage

`default_nettype wire

// ===== sv/sla_axis.sv =====
// Back-trace along one axis: idx - dt*v, floored to 12 fractional bits, clamped to the grid.
// Depends on sla_pkg.
`default_nettype none

module sla_axis #(
	parameter int GRID_SIZE = sla_pkg::GRID_SIZE_DEF
) (
	input  logic [sla_pkg::PIDX_W-1:0]        idx,
	input  logic signed [sla_pkg::PROD_W-1:0] prod,
	output logic [$clog2(GRID_SIZE)-1:0]      lo,
	output logic [sla_pkg::FRAC_W-1:0]        frac
);
	import sla_pkg::*;

	localparam int IDX_W = $clog2(GRID_SIZE);
	localparam int POS_W = IDX_W + FRAC_W;
	localparam int QW    = PIDX_W + 22 + 2;     // idx at 22 fractional bits, plus sign
	localparam int FW    = QW - 10;             // after flooring to 12 fractional bits
	localparam int PW    = ((POS_W > FW) ? POS_W : FW) + 1;
	localparam logic signed [PW-1:0] TOP_POS = PW'((GRID_SIZE - 1) * (2 ** FRAC_W));

	logic signed [QW-1:0] q;
	logic signed [PW-1:0] p;
	logic [POS_W-1:0]     pos;

	always_comb begin
		q = $signed({2'b00, idx, 22'd0}) - $signed({{(QW - PROD_W){prod[PROD_W-1]}}, prod});
		// dropping 10 low bits of a two's complement value floors it
		p = $signed({{(PW - FW){q[QW-1]}}, q[QW-1:10]});
		priority if (p < 0) begin
			pos = '0;
		end else if (p > TOP_POS) begin
			pos = TOP_POS[POS_W-1:0];
		end else begin
			pos = p[POS_W-1:0];
		end
		lo   = pos[POS_W-1:FRAC_W];
		frac = pos[FRAC_W-1:0];
	end

endmodule

`default_nettype wire

// ===== sv/sla_bank.sv =====
// One bank of the cell store: single write port, single read port, registered read data.
// No dependencies.
`default_nettype none

module sla_bank #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// holds while the following stage is stalled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/sla_blend.sv =====
// Bilinear blend datapath: weights, four weighted products, rounded sum.
// Depends on sla_pkg.
`default_nettype none

module sla_blend (
	input  logic                                  clk,
	input  sla_pkg::sla_adv_t                     adv,
	input  logic [sla_pkg::FRAC_W-1:0]            fx,   // stage 2
	input  logic [sla_pkg::FRAC_W-1:0]            fy,   // stage 2
	input  logic [3:0][sla_pkg::VAL_W-1:0]        nbr,  // stage 3: r0c0, r1c0, r0c1, r1c1
	output logic [sla_pkg::VAL_W-1:0]             result // stage 4
);
	import sla_pkg::*;

	localparam logic [FRAC_W:0]  ONE   = (FRAC_W + 1)'(2 ** FRAC_W);
	localparam logic [PP_W-1:0]  ROUND = PP_W'(2 ** (2 * FRAC_W - 1));

	logic [FRAC_W:0]      gx, gy, fxw, fyw;
	logic [WGT_W-1:0]     wgt [4];
	logic [WGT_W-1:0]     wgt_s3 [4];
	logic                 fxz_s3, fyz_s3;
	logic [VAL_W-1:0]     nbr_m [4];
	logic [PP_W-1:0]      prod_s4 [4];
	logic [PP_W-1:0]      sum;

	always_comb begin
		fxw = (FRAC_W + 1)'(fx);
		fyw = (FRAC_W + 1)'(fy);
		gx  = ONE - fxw;
		gy  = ONE - fyw;
		wgt[0] = WGT_W'(gx) * WGT_W'(gy);
		wgt[1] = WGT_W'(fxw) * WGT_W'(gy);
		wgt[2] = WGT_W'(gx) * WGT_W'(fyw);
		wgt[3] = WGT_W'(fxw) * WGT_W'(fyw);
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			for (int n = 0; n < 4; n++) begin
				wgt_s3[n] <= wgt[n];
			end
			fxz_s3 <= (fx == '0);
			fyz_s3 <= (fy == '0);
		end
	end

	// neighbours with zero weight may be unwritten or off the grid: keep them out
	always_comb begin
		for (int n = 0; n < 4; n++) begin
			if ((n[0] && fxz_s3) || (n[1] && fyz_s3)) begin
				nbr_m[n] = '0;
			end else begin
				nbr_m[n] = nbr[n];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			for (int n = 0; n < 4; n++) begin
				prod_s4[n] <= PP_W'(wgt_s3[n]) * PP_W'(nbr_m[n]);
			end
		end
	end

	// weights sum to 2^24, so the total fits in PP_W bits
	always_comb begin
		sum    = prod_s4[0] + prod_s4[1] + prod_s4[2] + prod_s4[3] + ROUND;
		result = sum[2*FRAC_W +: VAL_W];
	end

endmodule

`default_nettype wire

// ===== sv/semi_lagrangian_bilinear_advect.sv =====
// Semi-Lagrangian advection of a square scalar grid with bilinear blending: top level.
// Depends on sla_pkg, sla_axis, sla_bank and sla_blend.
//
// Usage: load the grid with write transactions (tuser opcode 0), each storing one Q1.15
// cell; then send sample transactions (opcode 1) with a cell and its Q2.14 velocity. Each
// sample returns one result: the value found by tracing the cell back by dt_step*velocity,
// clamping to the grid and blending the four surrounding cells; cells on the grid edge (or
// outside it) return 0 with is_border set. Writes return nothing. A cell must be written
// before any sample blends it. The block accepts one transaction per clock cycle and a
// sample passes through stages 1 to 4 and the output register; backpressure on the output
// stalls the pipeline only once its stages are full. The rate is set by the cell store,
// split into four banks by row and column parity so that the four neighbours of any
// position sit in different banks and are read in the same cycle. Writes go through the
// same memory stage as sample reads, so every sample sees all writes accepted before it,
// without forwarding. dt_step may only be written while no transaction is in flight.
`default_nettype none

module semi_lagrangian_bilinear_advect #(
	parameter int GRID_SIZE = sla_pkg::GRID_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              cfg_we,
	input  logic [sla_pkg::DT_W-1:0]          cfg_wdata,   // dt_step, unsigned Q4.8

	input  logic                              s_tvalid,
	output logic                              s_tready,
	// cell_row[6:0], cell_col[13:7], write_value[29:14], vel_x[45:30], vel_y[61:46], zero pad
	input  logic [sla_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic [0:0]                        s_tuser,     // opcode[0]

	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sla_pkg::OUT_DATA_W-1:0]    m_tdata,     // sample_value[15:0]
	output logic [0:0]                        m_tuser      // is_border[0]
);
	import sla_pkg::*;

	localparam int IDX_W = $clog2(GRID_SIZE);
	localparam int BA_W  = IDX_W - 1;          // per-bank row (or column) address
	localparam int XW    = (IDX_W > PIDX_W) ? IDX_W : PIDX_W;

	// ---- input field split ----
	logic [PIDX_W-1:0]       in_row, in_col;
	logic [VAL_W-1:0]        in_wval;
	logic signed [VEL_W-1:0] in_vx, in_vy;
	sla_op_t                 in_op;
	logic                    in_rng, in_border;

	assign in_row  = s_tdata[6:0];
	assign in_col  = s_tdata[13:7];
	assign in_wval = s_tdata[29:14];
	assign in_vx   = $signed(s_tdata[45:30]);
	assign in_vy   = $signed(s_tdata[61:46]);
	assign in_op   = sla_op_t'(s_tuser[0]);

	always_comb begin
		in_rng    = (int'(in_row) < GRID_SIZE) && (int'(in_col) < GRID_SIZE);
		in_border = !in_rng || (in_row == '0) || (in_col == '0) ||
		            (int'(in_row) == GRID_SIZE - 1) || (int'(in_col) == GRID_SIZE - 1);
	end

	// ---- time step register ----
	logic [DT_W-1:0] dt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RESET;
		end else if (cfg_we) begin
			dt_q <= cfg_wdata;
		end
	end

	// ---- pipeline flow control ----
	// Each stage loads when it is empty or its contents move on; writes leave after stage 2.
	sla_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic     ld1, ld2, ld3, ld4, ld_o;
	logic     out_valid_q;

	always_comb begin
		ld_o = !out_valid_q || m_tready;
		ld4  = !ctl_s4.valid || ld_o;
		ld3  = !ctl_s3.valid || ld4;
		ld2  = !ctl_s2.valid || ld3;
		ld1  = !ctl_s1.valid || ld2;
	end

	assign s_tready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			ctl_s4      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld1) begin
				ctl_s1.valid  <= s_tvalid;
				ctl_s1.sample <= (in_op == OP_SAMPLE);
				ctl_s1.border <= in_border;
				ctl_s1.wr     <= (in_op == OP_WRITE) && in_rng;
			end
			if (ld2) begin
				ctl_s2 <= ctl_s1;
			end
			if (ld3) begin
				ctl_s3.valid  <= ctl_s2.valid && ctl_s2.sample;
				ctl_s3.sample <= ctl_s2.sample;
				ctl_s3.border <= ctl_s2.border;
				ctl_s3.wr     <= ctl_s2.wr;
			end
			if (ld4) begin
				ctl_s4 <= ctl_s3;
			end
			if (ld_o) begin
				out_valid_q <= ctl_s4.valid;
			end
		end
	end

	// ---- stage 1: dt * v ----
	logic [PIDX_W-1:0]        row_s1, col_s1;
	logic [VAL_W-1:0]         wval_s1;
	logic signed [PROD_W-1:0] prodx_s1, prody_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			row_s1   <= in_row;
			col_s1   <= in_col;
			wval_s1  <= in_wval;
			prodx_s1 <= $signed({1'b0, dt_q}) * in_vx;
			prody_s1 <= $signed({1'b0, dt_q}) * in_vy;
		end
	end

	// ---- stage 2: traced position ----
	logic [IDX_W-1:0]  r0_c, c0_c;
	logic [FRAC_W-1:0] fx_c, fy_c;
	logic [XW-1:0]     row_x, col_x;

	sla_axis #(.GRID_SIZE(GRID_SIZE)) u_axis_row (
		.idx  (row_s1),
		.prod (prodx_s1),
		.lo   (r0_c),
		.frac (fx_c)
	);

	sla_axis #(.GRID_SIZE(GRID_SIZE)) u_axis_col (
		.idx  (col_s1),
		.prod (prody_s1),
		.lo   (c0_c),
		.frac (fy_c)
	);

	assign row_x = XW'(row_s1);
	assign col_x = XW'(col_s1);

	logic [IDX_W-1:0]  r0_s2, c0_s2, wrow_s2, wcol_s2;
	logic [FRAC_W-1:0] fx_s2, fy_s2;
	logic [VAL_W-1:0]  wval_s2;

	always_ff @(posedge clk) begin
		if (ld2) begin
			r0_s2   <= r0_c;
			c0_s2   <= c0_c;
			fx_s2   <= fx_c;
			fy_s2   <= fy_c;
			wrow_s2 <= row_x[IDX_W-1:0];
			wcol_s2 <= col_x[IDX_W-1:0];
			wval_s2 <= wval_s1;
		end
	end

	// ---- stage 3: banked cell store ----
	// Bank {pr,pc} holds cells with row parity pr and column parity pc. Of rows r0 and r0+1
	// the even one sits at (r0+1)>>1 and the odd one at r0>>1. When r0+1 runs off the grid
	// its weight is zero and the value read is ignored.
	logic [IDX_W:0]   r0p1, c0p1;
	logic [BA_W-1:0]  row_a [2];
	logic [BA_W-1:0]  col_a [2];
	logic             rd_go, wr_go;
	logic [VAL_W-1:0] bank_rd [4];
	logic             r0p_s3, c0p_s3;

	always_comb begin
		r0p1     = (IDX_W + 1)'(r0_s2) + (IDX_W + 1)'(1);
		c0p1     = (IDX_W + 1)'(c0_s2) + (IDX_W + 1)'(1);
		row_a[0] = r0p1[IDX_W-1:1];
		row_a[1] = r0_s2[IDX_W-1:1];
		col_a[0] = c0p1[IDX_W-1:1];
		col_a[1] = c0_s2[IDX_W-1:1];
		rd_go    = ld3 && ctl_s2.valid && ctl_s2.sample;
		wr_go    = ld3 && ctl_s2.valid && ctl_s2.wr;
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic bank_we;

		assign bank_we = wr_go && (wrow_s2[0] == b[1]) && (wcol_s2[0] == b[0]);

		sla_bank #(
			.ADDR_W (2 * BA_W),
			.DATA_W (VAL_W)
		) u_bank (
			.clk   (clk),
			.we    (bank_we),
			.waddr ({wrow_s2[IDX_W-1:1], wcol_s2[IDX_W-1:1]}),
			.wdata (wval_s2),
			.re    (rd_go),
			.raddr ({row_a[b[1]], col_a[b[0]]}),
			.rdata (bank_rd[b])
		);
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			r0p_s3 <= r0_s2[0];
			c0p_s3 <= c0_s2[0];
		end
	end

	// steer bank outputs to neighbour order r0c0, r1c0, r0c1, r1c1
	logic [3:0][VAL_W-1:0] nbr_s3;

	always_comb begin
		for (int n = 0; n < 4; n++) begin
			nbr_s3[n] = bank_rd[{r0p_s3 ^ n[0], c0p_s3 ^ n[1]}];
		end
	end

	// ---- stages 3 and 4: blend ----
	sla_adv_t         adv;
	logic [VAL_W-1:0] blend_val;

	assign adv.s3 = ld3;
	assign adv.s4 = ld4;

	sla_blend u_blend (
		.clk    (clk),
		.adv    (adv),
		.fx     (fx_s2),
		.fy     (fy_s2),
		.nbr    (nbr_s3),
		.result (blend_val)
	);

	// ---- output register ----
	logic [VAL_W-1:0] out_val_q;
	logic             out_border_q;

	always_ff @(posedge clk) begin
		if (ld_o) begin
			out_val_q    <= ctl_s4.border ? '0 : blend_val;
			out_border_q <= ctl_s4.border;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = OUT_DATA_W'(out_val_q);
	assign m_tuser[0] = out_border_q;

endmodule

`default_nettype wire
